FILE: src/dgcg_pkg.sv
package dgcg_pkg;

   // Field widths fixed by the interface
   localparam int ID_W     = 7;
   localparam int STATUS_W = 3;
   localparam int DEG_W    = 6;

   // Default graph size
   localparam int DGCG_MAX_NODES = 64;

   // Command codes
   localparam logic CMD_TASK = 1'b0;
   localparam logic CMD_EDGE = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STS_CYCLE     = 3'd1;
   localparam logic [STATUS_W-1:0] STS_FROM_MISS = 3'd2;
   localparam logic [STATUS_W-1:0] STS_TO_MISS   = 3'd3;
   localparam logic [STATUS_W-1:0] STS_SELF      = 3'd4;
   localparam logic [STATUS_W-1:0] STS_DUP       = 3'd5;
   localparam logic [STATUS_W-1:0] STS_FULL      = 3'd6;

   typedef struct packed {
      logic            cmd;
      logic [ID_W-1:0] from_id;
      logic [ID_W-1:0] to_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     new_task_id;
      logic [DEG_W-1:0]    target_in_degree;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK,
      S_CHECK,
      S_WALK,
      S_COMMIT,
      S_DONE
   } ctl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic req_load;
      logic task_add;
      logic look;
      logic check;
      logic walk;
      logic commit;
      logic rsp_load;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_edge;
      logic check_fail;
      logic walk_done;
      logic cycle_hit;
   } dp_stat_type;

endpackage

FILE: src/dgcg_ram.sv
module dgcg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: src/dgcg_ctl.sv
module dgcg_ctl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dgcg_pkg::dp_cmd_type dp_cmd,
   input  dgcg_pkg::dp_stat_type dp_stat
);
   import dgcg_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // State and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sequence one request through lookup, checks, walk and commit
   always_comb begin
      state_in  = state_ff;
      dp_cmd    = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.req_load = 1'b1;
               state_in        = S_LOOK;
            end
         end
         S_LOOK: begin
            if (dp_stat.is_edge) begin
               dp_cmd.look = 1'b1;
               state_in    = S_CHECK;
            end else begin
               dp_cmd.task_add = 1'b1;
               state_in        = S_DONE;
            end
         end
         S_CHECK: begin
            dp_cmd.check = 1'b1;
            state_in     = dp_stat.check_fail ? S_DONE : S_WALK;
         end
         S_WALK: begin
            dp_cmd.walk = 1'b1;
            if (dp_stat.walk_done) begin
               state_in = dp_stat.cycle_hit ? S_DONE : S_COMMIT;
            end
         end
         S_COMMIT: begin
            dp_cmd.commit = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               dp_cmd.rsp_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the result until taken
   always_comb begin
      if (dp_cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/dgcg_dp.sv
module dgcg_dp #(
   parameter int MAX_NODES = dgcg_pkg::DGCG_MAX_NODES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dgcg_pkg::req_type     req_data,
   output dgcg_pkg::rsp_type     rsp_data,
   input  dgcg_pkg::dp_cmd_type  dp_cmd,
   output dgcg_pkg::dp_stat_type dp_stat
);
   import dgcg_pkg::*;

   localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam logic [ID_W-1:0] MAX_ID = ID_W'(MAX_NODES);

   // Request and result registers
   req_type             req_ff;
   rsp_type             rsp_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ID_W-1:0]     new_id_ff, new_id_in;
   logic [DEG_W-1:0]    deg_ff, deg_in;

   // Graph state
   logic [ID_W-1:0]      task_count_ff, task_count_in;
   logic [MAX_NODES-1:0] adj_vld_ff, adj_vld_in;
   logic [MAX_NODES-1:0] deg_vld_ff, deg_vld_in;
   logic                 adj_rd_vld_ff, deg_rd_vld_ff;

   // Walk state
   logic [MAX_NODES-1:0] reach_ff, reach_in;
   logic [MAX_NODES-1:0] frontier_ff, frontier_in;
   logic [MAX_NODES-1:0] row_ff, row_in;
   logic                 inflight_ff, inflight_in;

   // Memory ports
   logic                 adj_rd_en, deg_rd_en;
   logic [IDX_W-1:0]     adj_rd_addr;
   logic [MAX_NODES-1:0] adj_rd_data, adj_wr_data;
   logic [DEG_W-1:0]     deg_rd_data, deg_wr_data;

   // Decoded ids
   logic [ID_W-1:0]      from_m1, to_m1, count_inc;
   logic [IDX_W-1:0]     from_idx, to_idx, pick_idx;
   logic                 from_ok, to_ok;
   logic [MAX_NODES-1:0] row_eff, fresh, pick_bit, to_bit;
   logic [DEG_W-1:0]     deg_cur;

   assign from_m1   = req_ff.from_id - ID_W'(1);
   assign to_m1     = req_ff.to_id - ID_W'(1);
   assign from_idx  = from_m1[IDX_W-1:0];
   assign to_idx    = to_m1[IDX_W-1:0];
   assign from_ok   = (req_ff.from_id != '0) && (req_ff.from_id <= task_count_ff);
   assign to_ok     = (req_ff.to_id != '0) && (req_ff.to_id <= task_count_ff);
   assign count_inc = task_count_ff + ID_W'(1);
   assign to_bit    = MAX_NODES'(1) << to_idx;

   // Rows never written read as empty
   assign row_eff = adj_rd_data & {MAX_NODES{adj_rd_vld_ff}};
   assign deg_cur = deg_rd_data & {DEG_W{deg_rd_vld_ff}};

   // Pick the lowest pending node of the frontier
   always_comb begin
      pick_idx = '0;
      for (int i = MAX_NODES - 1; i >= 0; i--) begin
         if (frontier_ff[i]) begin
            pick_idx = IDX_W'(i);
         end
      end
   end
   assign pick_bit = MAX_NODES'(1) << pick_idx;
   assign fresh    = inflight_ff ? (row_eff & ~reach_ff) : '0;

   // Memory read selection
   assign adj_rd_en   = dp_cmd.look || (dp_cmd.walk && (frontier_ff != '0));
   assign adj_rd_addr = dp_cmd.look ? from_idx : pick_idx;
   assign deg_rd_en   = dp_cmd.look;
   assign adj_wr_data = row_ff | to_bit;
   assign deg_wr_data = deg_ff + DEG_W'(1);

   dgcg_ram #(
      .WIDTH (MAX_NODES),
      .DEPTH (MAX_NODES)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (dp_cmd.commit),
      .wr_addr (from_idx),
      .wr_data (adj_wr_data),
      .rd_en   (adj_rd_en),
      .rd_addr (adj_rd_addr),
      .rd_data (adj_rd_data)
   );

   dgcg_ram #(
      .WIDTH (DEG_W),
      .DEPTH (MAX_NODES)
   ) u_deg_ram (
      .clock   (clock),
      .wr_en   (dp_cmd.commit),
      .wr_addr (to_idx),
      .wr_data (deg_wr_data),
      .rd_en   (deg_rd_en),
      .rd_addr (to_idx),
      .rd_data (deg_rd_data)
   );

   // Next values of result, graph and walk registers
   always_comb begin
      status_in     = status_ff;
      new_id_in     = new_id_ff;
      deg_in        = deg_ff;
      task_count_in = task_count_ff;
      adj_vld_in    = adj_vld_ff;
      deg_vld_in    = deg_vld_ff;
      reach_in      = reach_ff;
      frontier_in   = frontier_ff;
      row_in        = row_ff;
      inflight_in   = inflight_ff;

      if (dp_cmd.task_add) begin
         deg_in = '0;
         if (task_count_ff >= MAX_ID) begin
            status_in = STS_FULL;
            new_id_in = '0;
         end else begin
            status_in     = STS_OK;
            new_id_in     = count_inc;
            task_count_in = count_inc;
         end
      end

      if (dp_cmd.check) begin
         new_id_in   = '0;
         deg_in      = to_ok ? deg_cur : '0;
         row_in      = row_eff;
         reach_in    = to_bit;
         frontier_in = to_bit;
         inflight_in = 1'b0;
         priority if (!from_ok) begin
            status_in = STS_FROM_MISS;
         end else if (!to_ok) begin
            status_in = STS_TO_MISS;
         end else if (req_ff.from_id == req_ff.to_id) begin
            status_in = STS_SELF;
         end else if (row_eff[to_idx]) begin
            status_in = STS_DUP;
         end else begin
            status_in = STS_OK;
         end
      end

      // Retire the row in flight and issue the next from the frontier, if any, each cycle
      if (dp_cmd.walk) begin
         reach_in    = reach_ff | fresh;
         frontier_in = (frontier_ff & ~pick_bit) | fresh;
         inflight_in = (frontier_ff != '0);
         if (reach_ff[from_idx]) begin
            status_in = STS_CYCLE;
         end
      end

      if (dp_cmd.commit) begin
         adj_vld_in[from_idx] = 1'b1;
         deg_vld_in[to_idx]   = 1'b1;
         deg_in               = deg_wr_data;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= '0;
         adj_vld_ff    <= '0;
         deg_vld_ff    <= '0;
         inflight_ff   <= 1'b0;
      end else begin
         task_count_ff <= task_count_in;
         adj_vld_ff    <= adj_vld_in;
         deg_vld_ff    <= deg_vld_in;
         inflight_ff   <= inflight_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (dp_cmd.req_load) begin
         req_ff <= req_data;
      end
      if (adj_rd_en) begin
         adj_rd_vld_ff <= adj_vld_ff[adj_rd_addr];
      end
      if (deg_rd_en) begin
         deg_rd_vld_ff <= deg_vld_ff[to_idx];
      end
      if (dp_cmd.rsp_load) begin
         rsp_ff.status           <= status_ff;
         rsp_ff.new_task_id      <= new_id_ff;
         rsp_ff.target_in_degree <= deg_ff;
      end
      status_ff   <= status_in;
      new_id_ff   <= new_id_in;
      deg_ff      <= deg_in;
      reach_ff    <= reach_in;
      frontier_ff <= frontier_in;
      row_ff      <= row_in;
   end

   // Status toward the controller
   always_comb begin
      dp_stat.is_edge    = (req_ff.cmd == CMD_EDGE);
      dp_stat.check_fail = (status_in != STS_OK);
      dp_stat.walk_done  = ((frontier_ff == '0) && !inflight_ff) || reach_ff[from_idx];
      dp_stat.cycle_hit  = reach_ff[from_idx];
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: src/dependency_graph_cycle_guard_unit.sv
// Task dependency graph with cycle guard. Each request either adds a task
// (next id from 1 upward, or status full) or adds an edge from_id -> to_id,
// which is rejected when an id is missing, for a self edge, for a duplicate
// edge, or when to_id already reaches from_id. Exactly one response follows
// each request. An add-task request goes from the lookup state to the
// response register; an add-dependency request runs the simple checks
// and, if they pass, a reachability walk from to_id and then a commit (no
// commit follows when the walk finds a cycle). The walk issues at most one
// adjacency row read per cycle through the single read port of the row
// memory, and waits each time the frontier runs empty while a row is still
// in flight, as along a chain. The walk stops early once from_id is
// reached. One request is processed at a time; a new request is accepted
// while the previous response still waits. Reset clears the graph at once
// through per-row valid bits, so there is no clearing pass.
module dependency_graph_cycle_guard_unit #(
   parameter int MAX_NODES = dgcg_pkg::DGCG_MAX_NODES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dgcg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dgcg_pkg::rsp_type rsp_data
);
   import dgcg_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   dgcg_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat)
   );

   dgcg_dp #(
      .MAX_NODES (MAX_NODES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .dp_cmd   (dp_cmd),
      .dp_stat  (dp_stat)
   );

endmodule

FILE: dv/dependency_graph_cycle_guard_unit_test.sv
`timescale 1ns / 100ps

module dependency_graph_cycle_guard_unit_test;
   import dgcg_pkg::*;

   localparam int NODES       = DGCG_MAX_NODES;
   localparam int ID_TOP      = (1 << ID_W) - 1;
   localparam int RAND_ITEMS  = 1560;
   localparam int QUIET_FROM  = RAND_ITEMS - 90;
   localparam int HOLD_AT     = 400;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_WAIT  = 100;
   localparam int PRINT_CAP   = 50;

   typedef struct {
      req_type req;
      bit      known;
      rsp_type verdict;
   } step_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Mirror of the task graph
   int unsigned      task_total;
   logic [NODES-1:0] succ_rows [NODES];
   logic [DEG_W-1:0] fan_in [NODES];

   rsp_type      verdict_q[$];
   step_row_type directed_rows[$];
   int           mismatch_count;
   int           verdict_count;
   int           send_idle_pct;
   bit           quiet;
   bit           hold_done;

   dependency_graph_cycle_guard_unit #(
      .MAX_NODES (NODES)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic req_type make_req(logic cmd, int from_id, int to_id);
      req_type r;
      r.cmd     = cmd;
      r.from_id = ID_W'(from_id);
      r.to_id   = ID_W'(to_id);
      return r;
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 12;
         default: return 35;
      endcase
   endfunction

   function automatic bit id_known(logic [ID_W-1:0] id);
      return id >= 1 && id <= task_total;
   endfunction

   // Grow the reachable set from src until it stops changing
   function automatic bit reaches(int src, int dst);
      logic [NODES-1:0] reach;
      logic [NODES-1:0] grown;
      reach      = '0;
      reach[src] = 1'b1;
      grown      = reach;
      do begin
         reach = grown;
         for (int n = 0; n < NODES; n++)
            if (reach[n]) grown = grown | succ_rows[n];
      end while (grown != reach);
      return reach[dst];
   endfunction

   // Apply one request to the mirrored graph and return its verdict
   function automatic rsp_type graph_verdict(req_type r);
      rsp_type v;
      int      f;
      int      t;
      v = '0;
      f = r.from_id;
      t = r.to_id;
      if (r.cmd == CMD_TASK) begin
         if (task_total >= NODES) begin
            v.status = STS_FULL;
         end else begin
            task_total++;
            v.status      = STS_OK;
            v.new_task_id = ID_W'(task_total);
         end
      end else begin
         if (id_known(r.to_id)) v.target_in_degree = fan_in[t-1];
         if (!id_known(r.from_id)) begin
            v.status = STS_FROM_MISS;
         end else if (!id_known(r.to_id)) begin
            v.status = STS_TO_MISS;
         end else if (f == t) begin
            v.status = STS_SELF;
         end else if (succ_rows[f-1][t-1]) begin
            v.status = STS_DUP;
         end else if (reaches(t - 1, f - 1)) begin
            v.status = STS_CYCLE;
         end else begin
            succ_rows[f-1][t-1] = 1'b1;
            fan_in[t-1]         = fan_in[t-1] + 1'b1;
            v.status            = STS_OK;
            v.target_in_degree  = fan_in[t-1];
         end
      end
      return v;
   endfunction

   // Mostly edges between live tasks; some noise ids over the whole field
   function automatic req_type random_request();
      int roll;
      int span;
      int a;
      int b;
      int swap;
      roll = $urandom_range(0, 99);
      span = (task_total < 2) ? 2 : task_total;
      if (roll < ((task_total < NODES) ? 12 : 4))
         return make_req(CMD_TASK, $urandom_range(0, ID_TOP), $urandom_range(0, ID_TOP));
      if (roll < 22)
         return make_req(CMD_EDGE, $urandom_range(0, ID_TOP), $urandom_range(0, ID_TOP));
      a = $urandom_range(1, span);
      b = $urandom_range(1, span);
      // favor forward edges so chains get long; reversed ones probe the walk
      if ($urandom_range(0, 99) < 70 && a > b) begin
         swap = a;
         a    = b;
         b    = swap;
      end
      return make_req(CMD_EDGE, a, b);
   endfunction

   task automatic add_row(logic cmd, int from_id, int to_id, bit known,
                          logic [STATUS_W-1:0] status, int new_id, int deg);
      step_row_type row;
      row.req                      = make_req(cmd, from_id, to_id);
      row.known                    = known;
      row.verdict.status           = status;
      row.verdict.new_task_id      = ID_W'(new_id);
      row.verdict.target_in_degree = DEG_W'(deg);
      directed_rows.push_back(row);
   endtask

   task automatic report_mismatch(string field, int got, int want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("%0t: response %0d: %s got %0d want %0d",
                  $time, verdict_count, field, got, want);
   endtask

   // Offer one request, hold it until taken, then record its verdict
   task automatic offer_request(req_type r, bit known, rsp_type verdict);
      rsp_type predicted;
      if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = graph_verdict(r);
      verdict_q.push_back(known ? verdict : predicted);
      @(negedge clock);
   endtask

   // Compare each response with the oldest verdict
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         verdict_count++;
         if (verdict_q.size() == 0) begin
            report_mismatch("unexpected response, status", rsp_data.status, -1);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.new_task_id !== want.new_task_id)
               report_mismatch("new_task_id", rsp_data.new_task_id, want.new_task_id);
            if (rsp_data.target_in_degree !== want.target_in_degree)
               report_mismatch("target_in_degree", rsp_data.target_in_degree,
                               want.target_in_degree);
         end
      end
   end

   // Response side: random stall bursts, one long hold-off to back up the input
   initial begin
      int recv_idle_pct;
      int tick;
      rsp_ready     = 1'b0;
      recv_idle_pct = 0;
      tick          = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (tick % 256 == 0) recv_idle_pct = pick_idle_pct();
         if (!hold_done && verdict_count >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 99) < recv_idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Request side and end of run
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      task_total     = 0;
      mismatch_count = 0;
      verdict_count  = 0;
      send_idle_pct  = 0;
      quiet          = 1'b0;
      hold_done      = 1'b0;
      for (int n = 0; n < NODES; n++) begin
         succ_rows[n] = '0;
         fan_in[n]    = '0;
      end

      // Empty graph, missing ids at both ends of the field, self, duplicate,
      // cycles through one and two hops, add-task ignoring its ids
      add_row(CMD_EDGE,   1,   2, 1, STS_FROM_MISS, 0, 0);
      add_row(CMD_TASK, 127, 127, 1, STS_OK,        1, 0);
      add_row(CMD_TASK,   0,   0, 1, STS_OK,        2, 0);
      add_row(CMD_TASK,  85,  42, 1, STS_OK,        3, 0);
      add_row(CMD_EDGE,   0,   1, 1, STS_FROM_MISS, 0, 0);
      add_row(CMD_EDGE, 127,   2, 1, STS_FROM_MISS, 0, 0);
      add_row(CMD_EDGE,   4,   1, 1, STS_FROM_MISS, 0, 0);
      add_row(CMD_EDGE,   1,   0, 1, STS_TO_MISS,   0, 0);
      add_row(CMD_EDGE,   1, 127, 1, STS_TO_MISS,   0, 0);
      add_row(CMD_EDGE,   2,   2, 1, STS_SELF,      0, 0);
      add_row(CMD_EDGE,   1,   2, 1, STS_OK,        0, 1);
      add_row(CMD_EDGE,   1,   2, 1, STS_DUP,       0, 1);
      add_row(CMD_EDGE,   2,   1, 1, STS_CYCLE,     0, 0);
      add_row(CMD_EDGE,   2,   3, 1, STS_OK,        0, 1);
      add_row(CMD_EDGE,   3,   1, 1, STS_CYCLE,     0, 0);
      add_row(CMD_EDGE,   1,   3, 1, STS_OK,        0, 2);
      add_row(CMD_EDGE,   3,   2, 1, STS_CYCLE,     0, 1);
      add_row(CMD_TASK,   0, 127, 1, STS_OK,        4, 0);
      add_row(CMD_EDGE,   4,   4, 1, STS_SELF,      0, 0);
      add_row(CMD_EDGE,   3,   4, 1, STS_OK,        0, 1);
      add_row(CMD_EDGE,   4,   1, 1, STS_CYCLE,     0, 0);
      add_row(CMD_EDGE,   2,   4, 0, STS_OK,        0, 0);
      add_row(CMD_EDGE,   5,   1, 1, STS_FROM_MISS, 0, 0);
      add_row(CMD_EDGE,   1,   5, 1, STS_TO_MISS,   0, 0);
      add_row(CMD_EDGE,  64,  64, 1, STS_FROM_MISS, 0, 0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer_request(directed_rows[i].req, directed_rows[i].known,
                       directed_rows[i].verdict);

      // Random part: fills the graph to full, then keeps probing edges
      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (i % 64 == 0) send_idle_pct = pick_idle_pct();
         if (i >= QUIET_FROM) quiet = 1'b1;
         offer_request(random_request(), 1'b0, '0);
      end

      // Pile edges onto the last task to push its in-degree to the top
      for (int f = 1; f < NODES; f++)
         offer_request(make_req(CMD_EDGE, f, NODES), 1'b0, '0);

      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: files.f
src/dgcg_pkg.sv
src/dgcg_ram.sv
src/dgcg_ctl.sv
src/dgcg_dp.sv
src/dependency_graph_cycle_guard_unit.sv
dv/dependency_graph_cycle_guard_unit_test.sv
